>>> sv/esc_pkg.sv
// Shared types and constants of the expression syntax checker.
package esc_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int QUEUE_DEPTH = 2;
    localparam int POS_CAP     = (MAX_LEN - 1 < 1023) ? MAX_LEN - 1 : 1023;

    localparam logic [7:0]         SPACE_CH  = 8'h20;
    localparam logic [10:0]        IDX_MAX   = 11'd2047;
    localparam logic signed [11:0] DEPTH_MAX = 12'sh7FF;
    localparam logic signed [11:0] DEPTH_MIN = 12'sh800;

    typedef enum logic [3:0] {
        CLS_DIGIT,
        CLS_POINT,
        CLS_OP,
        CLS_MINUS,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_WORD,
        CLS_LETTER,
        CLS_OTHER
    } t_cls;

    typedef enum logic [3:0] {
        E_NONE       = 4'd0,
        E_EMPTY      = 4'd1,
        E_BR_COUNT   = 4'd2,
        E_EDGES      = 4'd3,
        E_EXTRA_VAR  = 4'd4,
        E_UNKNOWN    = 4'd5,
        E_SIGN       = 4'd6,
        E_POINT      = 4'd7,
        E_EMPTY_BR   = 4'd8,
        E_EXTRA_BR   = 4'd9,
        E_DIGIT      = 4'd10
    } t_err;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       space;
        t_cls       cls;
    } t_entry;

    typedef struct packed {
        t_err               code;
        logic signed [11:0] depth;
    } t_scan;

endpackage

>>> sv/esc_front.sv
// Input stage: accepts characters and classifies them for the queue.
module esc_front (
    input  logic              i_in_valid,
    input  logic [7:0]        i_ch,
    input  logic              i_last,
    input  logic              i_full,
    output logic              o_in_ready,
    output logic              o_push,
    output esc_pkg::t_entry   o_entry
);

    esc_pkg::t_cls cls;

    always_comb begin
        case (i_ch) inside
            ["0":"9"]:                   cls = esc_pkg::CLS_DIGIT;
            ".":                         cls = esc_pkg::CLS_POINT;
            "-":                         cls = esc_pkg::CLS_MINUS;
            "+", "*", "/", "^":          cls = esc_pkg::CLS_OP;
            "(":                         cls = esc_pkg::CLS_LPAREN;
            ")":                         cls = esc_pkg::CLS_RPAREN;
            "c", "o", "s", "i", "n", "e",
            "x", "p", "t", "a", "l":     cls = esc_pkg::CLS_WORD;
            ["a":"z"], ["A":"Z"]:        cls = esc_pkg::CLS_LETTER;
            default:                     cls = esc_pkg::CLS_OTHER;
        endcase
    end

    assign o_in_ready    = ~i_full;
    assign o_push        = i_in_valid & ~i_full;
    assign o_entry.ch    = i_ch;
    assign o_entry.last  = i_last;
    assign o_entry.space = (i_ch == esc_pkg::SPACE_CH);
    assign o_entry.cls   = cls;

endmodule

>>> sv/esc_queue.sv
// Small FIFO between the classifier and the checking stage.
module esc_queue #(
    parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  esc_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output esc_pkg::t_entry o_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    esc_pkg::t_entry   r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_pop;

    assign do_pop  = i_pop & (r_count != '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> sv/esc_back.sv
// Checking stage: neighbour checks, bracket depth, first error and result register.
module esc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  esc_pkg::t_entry i_q_entry,
    output logic            o_pop,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic            o_ok,
    output logic [3:0]      o_err_code,
    output logic [7:0]      o_bad_char,
    output logic [9:0]      o_bad_pos
);

    function automatic logic op_pt(esc_pkg::t_cls k);
        return (k == esc_pkg::CLS_OP) || (k == esc_pkg::CLS_MINUS) || (k == esc_pkg::CLS_POINT);
    endfunction

    function automatic logic nb_ok(esc_pkg::t_cls k, esc_pkg::t_cls br);
        return (k == esc_pkg::CLS_DIGIT) || op_pt(k) || (k == br);
    endfunction

    function automatic logic [9:0] clip_pos(logic [10:0] idx);
        return (idx > 11'(esc_pkg::POS_CAP)) ? 10'(esc_pkg::POS_CAP) : idx[9:0];
    endfunction

    function automatic esc_pkg::t_scan scan_one(
        esc_pkg::t_cls      c,
        esc_pkg::t_cls      prev,
        esc_pkg::t_cls      nxt,
        logic               idx_zero,
        logic               at_end,
        logic signed [11:0] depth
    );
        esc_pkg::t_scan s;
        logic           bad;
        s.code  = esc_pkg::E_NONE;
        s.depth = depth;
        bad     = 1'b0;
        if (c == esc_pkg::CLS_LETTER) begin
            s.code = esc_pkg::E_EXTRA_VAR;
        end else if (c == esc_pkg::CLS_OTHER) begin
            s.code = esc_pkg::E_UNKNOWN;
        end else begin
            if (c == esc_pkg::CLS_OP) begin
                if ((op_pt(prev) || op_pt(nxt)) && nxt != esc_pkg::CLS_MINUS) begin
                    s.code = esc_pkg::E_SIGN;
                end else if (prev == esc_pkg::CLS_MINUS && nxt == esc_pkg::CLS_MINUS) begin
                    s.code = esc_pkg::E_SIGN;
                end
            end
            case (c)
                esc_pkg::CLS_POINT: begin
                    if (s.code == esc_pkg::E_NONE &&
                        (prev != esc_pkg::CLS_DIGIT || nxt != esc_pkg::CLS_DIGIT)) begin
                        s.code = esc_pkg::E_POINT;
                    end
                end
                esc_pkg::CLS_LPAREN: begin
                    if (s.depth != esc_pkg::DEPTH_MAX) begin
                        s.depth = s.depth + 12'sd1;
                    end
                    if (s.code == esc_pkg::E_NONE && nxt == esc_pkg::CLS_RPAREN) begin
                        s.code = esc_pkg::E_EMPTY_BR;
                    end
                end
                esc_pkg::CLS_RPAREN: begin
                    if (s.depth != esc_pkg::DEPTH_MIN) begin
                        s.depth = s.depth - 12'sd1;
                    end
                    if (s.code == esc_pkg::E_NONE && s.depth < 0) begin
                        s.code = esc_pkg::E_EXTRA_BR;
                    end
                end
                esc_pkg::CLS_DIGIT: begin
                    if (!at_end && !nb_ok(nxt, esc_pkg::CLS_RPAREN)) begin
                        bad = 1'b1;
                    end
                    if (!idx_zero && !nb_ok(prev, esc_pkg::CLS_LPAREN)) begin
                        bad = 1'b1;
                    end
                    if (s.code == esc_pkg::E_NONE && bad) begin
                        s.code = esc_pkg::E_DIGIT;
                    end
                end
                default: begin
                end
            endcase
        end
        return s;
    endfunction

    logic               r_held_valid;
    logic [7:0]         r_held_ch;
    esc_pkg::t_cls      r_held_cls;
    esc_pkg::t_cls      r_before_cls;
    esc_pkg::t_cls      r_first_cls;
    logic [10:0]        r_idx;
    logic signed [11:0] r_depth;
    esc_pkg::t_err      r_err_code;
    logic [7:0]         r_err_ch;
    logic [9:0]         r_err_pos;

    logic               r_out_valid;
    logic               r_ok;
    esc_pkg::t_err      r_code;
    logic [7:0]         r_bad_ch;
    logic [9:0]         r_bad_pos;

    logic               take, do_a;
    logic [10:0]        idx_a, idx_b;
    esc_pkg::t_scan     scan_a, scan_b;
    logic signed [11:0] depth_a, depth_b;
    esc_pkg::t_err      err1_code, err2_code;
    logic [7:0]         err1_ch, err2_ch;
    logic [9:0]         err1_pos, err2_pos;
    logic               n_held_valid;
    logic [7:0]         n_held_ch;
    esc_pkg::t_cls      n_held_cls, n_before_cls, n_first_cls;
    logic [10:0]        n_idx;
    esc_pkg::t_err      n_code;
    logic [7:0]         n_bad_ch;
    logic [9:0]         n_bad_pos;

    assign o_pop = i_q_valid & (~i_q_entry.last | ~r_out_valid | i_out_ready);

    always_comb begin
        take   = ~i_q_entry.space;
        do_a   = take & r_held_valid;
        idx_a  = r_idx - 11'd1;
        scan_a = scan_one(r_held_cls, r_before_cls, i_q_entry.cls, (idx_a == '0), 1'b0,
                          r_depth);
        depth_a = do_a ? scan_a.depth : r_depth;

        err1_code = r_err_code;
        err1_ch   = r_err_ch;
        err1_pos  = r_err_pos;
        if (do_a && scan_a.code != esc_pkg::E_NONE && r_err_code == esc_pkg::E_NONE) begin
            err1_code = scan_a.code;
            err1_ch   = r_held_ch;
            err1_pos  = clip_pos(idx_a);
        end

        n_held_valid = r_held_valid | take;
        n_held_ch    = take ? i_q_entry.ch : r_held_ch;
        n_held_cls   = take ? i_q_entry.cls : r_held_cls;
        n_before_cls = do_a ? r_held_cls : r_before_cls;
        n_first_cls  = (take && !r_held_valid) ? i_q_entry.cls : r_first_cls;
        n_idx        = (take && r_idx != esc_pkg::IDX_MAX) ? r_idx + 11'd1 : r_idx;

        // End of expression: the held character sees a space on its right.
        idx_b   = n_idx - 11'd1;
        scan_b  = scan_one(n_held_cls, n_before_cls, esc_pkg::CLS_OTHER, (idx_b == '0), 1'b1,
                           depth_a);
        depth_b = n_held_valid ? scan_b.depth : depth_a;

        err2_code = err1_code;
        err2_ch   = err1_ch;
        err2_pos  = err1_pos;
        if (n_held_valid && scan_b.code != esc_pkg::E_NONE && err1_code == esc_pkg::E_NONE) begin
            err2_code = scan_b.code;
            err2_ch   = n_held_ch;
            err2_pos  = clip_pos(idx_b);
        end

        n_bad_ch  = '0;
        n_bad_pos = '0;
        if (!n_held_valid) begin
            n_code = esc_pkg::E_EMPTY;
        end else if (depth_b != 12'sd0) begin
            n_code = esc_pkg::E_BR_COUNT;
        end else if (n_first_cls == esc_pkg::CLS_OP || n_first_cls == esc_pkg::CLS_POINT ||
                     op_pt(n_held_cls)) begin
            n_code = esc_pkg::E_EDGES;
        end else begin
            n_code = err2_code;
            if (err2_code != esc_pkg::E_NONE) begin
                n_bad_ch  = err2_ch;
                n_bad_pos = err2_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_q_entry.last)) begin
            r_held_valid <= 1'b0;
            r_held_ch    <= esc_pkg::SPACE_CH;
            r_held_cls   <= esc_pkg::CLS_OTHER;
            r_before_cls <= esc_pkg::CLS_OTHER;
            r_first_cls  <= esc_pkg::CLS_OTHER;
            r_idx        <= '0;
            r_depth      <= '0;
            r_err_code   <= esc_pkg::E_NONE;
            r_err_ch     <= '0;
            r_err_pos    <= '0;
        end else if (o_pop) begin
            r_held_valid <= n_held_valid;
            r_held_ch    <= n_held_ch;
            r_held_cls   <= n_held_cls;
            r_before_cls <= n_before_cls;
            r_first_cls  <= n_first_cls;
            r_idx        <= n_idx;
            r_depth      <= depth_a;
            r_err_code   <= err1_code;
            r_err_ch     <= err1_ch;
            r_err_pos    <= err1_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_q_entry.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_entry.last) begin
            r_ok      <= (n_code == esc_pkg::E_NONE);
            r_code    <= n_code;
            r_bad_ch  <= n_bad_ch;
            r_bad_pos <= n_bad_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_err_code  = r_code;
    assign o_bad_char  = r_bad_ch;
    assign o_bad_pos   = r_bad_pos;

`ifndef ASSERT_OFF
    a_idx_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held_valid |-> (r_idx == '0))
        else $error("index nonzero with no held character");

    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held_valid |-> (r_err_code == esc_pkg::E_NONE))
        else $error("scan error recorded before any character");

    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_ok == (r_code == esc_pkg::E_NONE)))
        else $error("ok flag disagrees with error code");

    a_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_code == esc_pkg::E_NONE || r_code == esc_pkg::E_EMPTY ||
                         r_code == esc_pkg::E_BR_COUNT || r_code == esc_pkg::E_EDGES))
        |-> (r_bad_ch == '0 && r_bad_pos == '0))
        else $error("position reported for a whole-expression error");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_code)))
        else $error("result lost while stalled");
`endif

endmodule

>>> sv/expression_syntax_checker_top.sv
// Top level of the expression syntax checker: classifier, queue and checking stage.
// Throughput: one character per cycle, sustained, with the output ready.
// The last character is written into the queue at its transfer; the checking stage
// then pops it and loads the result register once that register is empty or being read.
// The result register lets the next expression's characters enter while a result waits.
// Reset: synchronous, active low; clears queue pointers, scan state and result valid.
module expression_syntax_checker_top #(
    parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_ok,
    output logic [3:0] o_err_code,
    output logic [7:0] o_bad_char,
    output logic [9:0] o_bad_pos
);

    esc_pkg::t_entry push_entry;
    esc_pkg::t_entry q_entry;
    logic            push, full, q_valid, pop;

    esc_front u_front (
        .i_in_valid (i_in_valid),
        .i_ch       (i_ch),
        .i_last     (i_last),
        .i_full     (full),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    esc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    esc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_pop       (pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_ok        (o_ok),
        .o_err_code  (o_err_code),
        .o_bad_char  (o_bad_char),
        .o_bad_pos   (o_bad_pos)
    );

endmodule

>>> test/testbench.sv
// Testbench of the expression syntax checker: directed, random and long expressions vs a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int INDEX_TOP    = 2047;
    localparam int DEPTH_TOP    = 2047;
    localparam int DEPTH_BOTTOM = -2048;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    typedef struct {
        bit            ok;
        esc_pkg::t_err code;
        logic [7:0]    bad_ch;
        logic [9:0]    bad_pos;
    } t_verdict;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_ch;
    logic       i_last;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_ok;
    logic [3:0] o_err_code;
    logic [7:0] o_bad_char;
    logic [9:0] o_bad_pos;

    expression_syntax_checker_top i_dut (.*);

    // predictor state for the expression in progress
    logic [7:0]    p_held;
    logic [7:0]    p_prev;
    logic [7:0]    p_first;
    bit            p_held_v;
    int            p_count;
    int            p_depth;
    esc_pkg::t_err p_err;
    logic [7:0]    p_err_ch;
    logic [9:0]    p_err_pos;

    t_verdict   pending_verdicts[$];
    logic [7:0] expr_buf[$];
    string      symbol_pool = "0123456789.+-*/^()cosinexptal yZ";

    t_rx_mode   rx_mode = RX_ALWAYS;
    int         rx_tick = 0;
    int         rx_period = 4;
    int         rx_open = 2;
    bit         tx_gaps;
    int         burst_left;

    int         idle_cycles;
    int         mismatches;
    int         chars_in;
    int         kept_sent;
    int         exprs_sent;
    int         verdicts_checked;
    int         code_seen[16];

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic bit is_op(logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "^";
    endfunction

    function automatic bit is_op_pt(logic [7:0] c);
        return is_op(c) || c == ".";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_allowed(logic [7:0] c);
        case (c)
            ".", "(", ")", "c", "o", "s", "i", "n", "e", "x", "p", "t", "a", "l": return 1'b1;
            default: return is_digit(c) || is_op(c);
        endcase
    endfunction

    function automatic bit neighbor_ok(logic [7:0] c, logic [7:0] bracket);
        return is_digit(c) || c == "." || is_op(c) || c == bracket;
    endfunction

    function automatic void reset_scan();
        p_held    = esc_pkg::SPACE_CH;
        p_held_v  = 1'b0;
        p_prev    = esc_pkg::SPACE_CH;
        p_first   = 8'h00;
        p_count   = 0;
        p_depth   = 0;
        p_err     = esc_pkg::E_NONE;
        p_err_ch  = 8'h00;
        p_err_pos = 10'd0;
    endfunction

    // check one kept character against its neighbors, keep the first error
    function automatic void scan_char(logic [7:0] c, logic [7:0] prev_c, logic [7:0] next_c,
                                      int pos, bit at_end);
        esc_pkg::t_err code;
        bit            bad;
        code = esc_pkg::E_NONE;
        bad  = 1'b0;
        if (!is_allowed(c)) begin
            code = is_letter(c) ? esc_pkg::E_EXTRA_VAR : esc_pkg::E_UNKNOWN;
        end else begin
            if (is_op(c) && c != "-") begin
                if ((is_op_pt(prev_c) || is_op_pt(next_c)) && next_c != "-")
                    code = esc_pkg::E_SIGN;
                else if (prev_c == "-" && next_c == "-")
                    code = esc_pkg::E_SIGN;
            end
            if (c == ".") begin
                if (code == esc_pkg::E_NONE && (!is_digit(prev_c) || !is_digit(next_c)))
                    code = esc_pkg::E_POINT;
            end else if (c == "(") begin
                if (p_depth < DEPTH_TOP)
                    p_depth++;
                if (code == esc_pkg::E_NONE && next_c == ")")
                    code = esc_pkg::E_EMPTY_BR;
            end else if (c == ")") begin
                if (p_depth > DEPTH_BOTTOM)
                    p_depth--;
                if (code == esc_pkg::E_NONE && p_depth < 0)
                    code = esc_pkg::E_EXTRA_BR;
            end else if (is_digit(c)) begin
                if (!at_end && !neighbor_ok(next_c, ")"))
                    bad = 1'b1;
                if (pos != 0 && !neighbor_ok(prev_c, "("))
                    bad = 1'b1;
                if (code == esc_pkg::E_NONE && bad)
                    code = esc_pkg::E_DIGIT;
            end
        end
        if (code != esc_pkg::E_NONE && p_err == esc_pkg::E_NONE) begin
            p_err     = code;
            p_err_ch  = c;
            p_err_pos = 10'((pos > esc_pkg::POS_CAP) ? esc_pkg::POS_CAP : pos);
        end
    endfunction

    function automatic void predict_char(logic [7:0] c, bit fin);
        t_verdict      v;
        esc_pkg::t_err code;
        if (c != esc_pkg::SPACE_CH) begin
            if (p_held_v) begin
                scan_char(p_held, p_prev, c, p_count - 1, 1'b0);
                p_prev = p_held;
            end else begin
                p_first = c;
            end
            p_held   = c;
            p_held_v = 1'b1;
            if (p_count < INDEX_TOP)
                p_count++;
        end
        if (fin) begin
            if (p_held_v)
                scan_char(p_held, p_prev, esc_pkg::SPACE_CH, p_count - 1, 1'b1);
            v.bad_ch  = 8'h00;
            v.bad_pos = 10'd0;
            if (!p_held_v) begin
                code = esc_pkg::E_EMPTY;
            end else if (p_depth != 0) begin
                code = esc_pkg::E_BR_COUNT;
            end else if ((is_op_pt(p_first) && p_first != "-") || is_op_pt(p_held)) begin
                code = esc_pkg::E_EDGES;
            end else begin
                code      = p_err;
                v.bad_ch  = p_err_ch;
                v.bad_pos = p_err_pos;
            end
            v.ok   = code == esc_pkg::E_NONE;
            v.code = code;
            pending_verdicts.push_back(v);
            code_seen[code]++;
            reset_scan();
        end
    endfunction

    // transfers are decided by values that are stable over the low half of the clock
    always @(negedge i_clk) begin
        t_verdict v;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_char(i_ch, i_last);
                chars_in++;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with none pending: ok=%0d code=%0d char=%h pos=%0d",
                                 $realtime, o_ok, o_err_code, o_bad_char, o_bad_pos);
                end else begin
                    v = pending_verdicts.pop_front();
                    verdicts_checked++;
                    if (o_ok !== v.ok || o_err_code !== v.code || o_bad_char !== v.bad_ch ||
                        o_bad_pos !== v.bad_pos) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected ok=%0d code=%0d char=%h pos=%0d, got %0d %0d %h %0d",
                                     $realtime, v.ok, v.code, v.bad_ch, v.bad_pos,
                                     o_ok, o_err_code, o_bad_char, o_bad_pos);
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else if (++idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("[expression_syntax_checker_top] ERROR");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 64 == 0) begin
            rx_period <= $urandom_range(1, 12);
            rx_open   <= $urandom_range(0, 12);
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= $urandom_range(0, 3) != 0;
                default:   i_out_ready <= (rx_tick % rx_period) < rx_open;
            endcase
        end
    end

    task automatic hold_off(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // called at a rising edge; returns at the edge of the transfer, or later when gaps are on
    task automatic send_char(logic [7:0] c, bit fin);
        bit taken;
        i_in_valid <= 1'b1;
        i_ch       <= c;
        i_last     <= fin;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        if (tx_gaps) begin
            if (burst_left == 0) begin
                hold_off($urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_expr();
        for (int k = 0; k < expr_buf.size(); k++) begin
            send_char(expr_buf[k], k == expr_buf.size() - 1);
            if (expr_buf[k] != esc_pkg::SPACE_CH)
                kept_sent++;
        end
        exprs_sent++;
    endtask

    function automatic void push_str(string s);
        for (int k = 0; k < s.len(); k++)
            expr_buf.push_back(s[k]);
    endfunction

    task automatic send_text(string s);
        expr_buf.delete();
        push_str(s);
        send_expr();
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [7:0] noise_char();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        return symbol_pool[$urandom_range(0, symbol_pool.len() - 1)];
    endfunction

    function automatic void gen_number();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) expr_buf.push_back(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
            expr_buf.push_back(".");
            n = $urandom_range(1, 3);
            repeat (n) expr_buf.push_back(8'("0" + $urandom_range(0, 9)));
        end
    endfunction

    function automatic void gen_term(int level);
        case ($urandom_range(0, level < 3 ? 5 : 2))
            0, 1: gen_number();
            2: begin
                case ($urandom_range(0, 2))
                    0: push_str("x");
                    1: push_str("e");
                    default: push_str("pi");
                endcase
            end
            3: begin
                expr_buf.push_back("(");
                gen_expr(level + 1);
                expr_buf.push_back(")");
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: push_str("cos");
                    1: push_str("sin");
                    2: push_str("exp");
                    default: push_str("ln");
                endcase
                expr_buf.push_back("(");
                gen_expr(level + 1);
                expr_buf.push_back(")");
            end
        endcase
    endfunction

    function automatic void gen_expr(int level);
        int terms;
        terms = $urandom_range(1, 4);
        for (int k = 0; k < terms; k++) begin
            if (k > 0) begin
                case ($urandom_range(0, 4))
                    0: expr_buf.push_back("+");
                    1: expr_buf.push_back("-");
                    2: expr_buf.push_back("*");
                    3: expr_buf.push_back("/");
                    default: expr_buf.push_back("^");
                endcase
            end
            if ($urandom_range(0, 5) == 0)
                expr_buf.push_back("-");
            gen_term(level);
        end
    endfunction

    function automatic void mutate();
        int         pos;
        logic [7:0] c;
        pos = $urandom_range(0, expr_buf.size() - 1);
        case ($urandom_range(0, 3))
            0: expr_buf[pos] = noise_char();
            1: expr_buf.insert(pos, noise_char());
            2: begin
                if (expr_buf.size() > 1)
                    expr_buf.delete(pos);
            end
            default: begin
                if (pos + 1 < expr_buf.size()) begin
                    c                 = expr_buf[pos];
                    expr_buf[pos]     = expr_buf[pos + 1];
                    expr_buf[pos + 1] = c;
                end
            end
        endcase
    endfunction

    // mostly well-formed expressions, some broken ones, some noise
    function automatic void build_random_expr();
        int roll;
        expr_buf.delete();
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            repeat ($urandom_range(1, 3)) expr_buf.push_back(esc_pkg::SPACE_CH);
        end else if (roll < 13) begin
            repeat ($urandom_range(1, 10)) expr_buf.push_back(noise_char());
        end else begin
            gen_expr(0);
            if (roll >= 68)
                repeat ($urandom_range(1, 3)) mutate();
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                expr_buf.insert($urandom_range(0, expr_buf.size()), esc_pkg::SPACE_CH);
        if ($urandom_range(0, 7) == 0)
            expr_buf.push_back(esc_pkg::SPACE_CH);
    endfunction

    task automatic test_directed_cases();
        tx_gaps = 1'b0;
        rx_mode <= RX_ALWAYS;
        send_text(" ");
        send_text("7");
        send_text("-5");
        send_text("*5");
        send_text("()");
        send_text("(1");
        send_text("1)(");
        send_text("1^/2");
        send_text("-.5");
        send_text("2a");
        send_text("y");
        expr_buf.delete();
        expr_buf.push_back(8'hFF);
        send_expr();
    endtask

    task automatic test_random_flow(int chars, bit gaps, t_rx_mode mode);
        int start;
        start   = kept_sent;
        tx_gaps = gaps;
        rx_mode <= mode;
        while (kept_sent - start < chars) begin
            build_random_expr();
            send_expr();
        end
    endtask

    // reported position beyond the cap
    task automatic test_long_positions();
        tx_gaps = 1'b0;
        rx_mode <= RX_RANDOM;
        expr_buf.delete();
        repeat (515) push_str("1+");
        push_str("1");
        expr_buf[1026] = "y";
        send_expr();
    endtask

    initial begin
        string codes;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_ch       = esc_pkg::SPACE_CH;
        i_last     = 1'b0;
        tx_gaps    = 1'b0;
        burst_left = 0;
        reset_scan();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_flow(230, 1'b0, RX_ALWAYS);
        test_random_flow(230, 1'b1, RX_RANDOM);
        wait_for_results();
        test_random_flow(200, 1'b1, RX_PATTERN);
        test_long_positions();

        rx_mode <= RX_ALWAYS;
        wait_for_results();

        codes = "";
        for (int k = 0; k <= esc_pkg::E_DIGIT; k++)
            codes = {codes, $sformatf(" %0d:%0d", k, code_seen[k])};
        $display("Sent %0d expressions, %0d characters (%0d not spaces), checked %0d verdicts.",
                 exprs_sent, chars_in, kept_sent, verdicts_checked);
        $display("Verdicts by error code:%s", codes);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("[expression_syntax_checker_top] OK");
        end else begin
            $display("%0d mismatches, %0d verdicts never produced",
                     mismatches, pending_verdicts.size());
            $display("[expression_syntax_checker_top] ERROR");
        end
        $finish;
    end

endmodule
